// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks clocked on aclk and held off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define WER_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// antecedent implies consequent in the next cycle
`define WER_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define WER_ASSERT_IMP(label, ante, cons, msg)
`define WER_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== rtl/wer_pkg.sv =====
// ----------------------------------------------------------------------------
// wer_pkg
// Shared sizes, codes and types of the write-entry ring with offset lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package wer_pkg;

    localparam int DEPTH    = 16;
    localparam int PTR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int ACTION_W = 2;
    localparam int HANDLE_W = 32;
    localparam int SIZE_W   = 16;
    localparam int OFFSET_W = 20;
    localparam int INDEX_W  = 4;
    // running byte total: wide enough for every size summed, and for the offset
    localparam int SUM_W    = (((SIZE_W + CNT_W) > OFFSET_W) ? (SIZE_W + CNT_W) : OFFSET_W) + 1;

    localparam logic [ACTION_W-1:0] ACT_ADD  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FIND = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_POP  = 2'd2;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_POP_RD,
        OP_POP_DONE,
        OP_ADD_RD,
        OP_ADD_WR,
        OP_FIND_INIT,
        OP_FIND_WALK,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_XFER,
        C_IS_FIND,
        C_IS_ADD,
        C_WALK_BUSY,
        C_OUT_BUSY
    } cond_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISP_FIND,
        ST_DISP_ADD,
        ST_POP_RD,
        ST_POP_DONE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_FIND_INIT,
        ST_FIND_WALK,
        ST_EMIT
    } step_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t jump;
        step_t next;
    } uword_t;

    typedef struct packed {
        op_t  op;
        logic xfer;
    } ctrl_t;

    typedef struct packed {
        logic is_add;
        logic is_find;
        logic walk_done;
        logic out_busy;
    } status_t;

    function automatic ptr_t ring_next(input ptr_t p);
        if (p == ptr_t'(DEPTH - 1)) begin
            return '0;
        end
        return p + ptr_t'(1);
    endfunction

    function automatic logic [INDEX_W-1:0] to_index(input ptr_t p);
        logic [PTR_W+INDEX_W-1:0] w;
        w = {{INDEX_W{1'b0}}, p};
        return w[INDEX_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/wer_seq.sv =====
// ----------------------------------------------------------------------------
// wer_seq
// Microcode sequencer: step register, control-word table and jump logic.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module wer_seq (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire wer_pkg::status_t status,
    output wer_pkg::ctrl_t       ctrl
);

    wer_pkg::step_t  step_reg;
    wer_pkg::step_t  step_next;
    wer_pkg::uword_t uw;
    logic            take;

    // control store
    function automatic wer_pkg::uword_t urom(input wer_pkg::step_t s);
        wer_pkg::uword_t w;
        unique case (s)
            wer_pkg::ST_IDLE:      w = '{wer_pkg::OP_ACCEPT,    wer_pkg::C_NO_XFER,
                                         wer_pkg::ST_IDLE,      wer_pkg::ST_DISP_FIND};
            wer_pkg::ST_DISP_FIND: w = '{wer_pkg::OP_NOP,       wer_pkg::C_IS_FIND,
                                         wer_pkg::ST_FIND_INIT, wer_pkg::ST_DISP_ADD};
            wer_pkg::ST_DISP_ADD:  w = '{wer_pkg::OP_NOP,       wer_pkg::C_IS_ADD,
                                         wer_pkg::ST_ADD_RD,    wer_pkg::ST_POP_RD};
            wer_pkg::ST_POP_RD:    w = '{wer_pkg::OP_POP_RD,    wer_pkg::C_NEVER,
                                         wer_pkg::ST_IDLE,      wer_pkg::ST_POP_DONE};
            wer_pkg::ST_POP_DONE:  w = '{wer_pkg::OP_POP_DONE,  wer_pkg::C_NEVER,
                                         wer_pkg::ST_IDLE,      wer_pkg::ST_EMIT};
            wer_pkg::ST_ADD_RD:    w = '{wer_pkg::OP_ADD_RD,    wer_pkg::C_NEVER,
                                         wer_pkg::ST_IDLE,      wer_pkg::ST_ADD_WR};
            wer_pkg::ST_ADD_WR:    w = '{wer_pkg::OP_ADD_WR,    wer_pkg::C_NEVER,
                                         wer_pkg::ST_IDLE,      wer_pkg::ST_EMIT};
            wer_pkg::ST_FIND_INIT: w = '{wer_pkg::OP_FIND_INIT, wer_pkg::C_NEVER,
                                         wer_pkg::ST_IDLE,      wer_pkg::ST_FIND_WALK};
            wer_pkg::ST_FIND_WALK: w = '{wer_pkg::OP_FIND_WALK, wer_pkg::C_WALK_BUSY,
                                         wer_pkg::ST_FIND_WALK, wer_pkg::ST_EMIT};
            wer_pkg::ST_EMIT:      w = '{wer_pkg::OP_EMIT,      wer_pkg::C_OUT_BUSY,
                                         wer_pkg::ST_EMIT,      wer_pkg::ST_IDLE};
            default:               w = '{wer_pkg::OP_NOP,       wer_pkg::C_ALWAYS,
                                         wer_pkg::ST_IDLE,      wer_pkg::ST_IDLE};
        endcase
        return w;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= wer_pkg::ST_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

    always_comb begin
        uw      = urom(step_reg);
        s_ready = (uw.op == wer_pkg::OP_ACCEPT);
        unique case (uw.cond)
            wer_pkg::C_NEVER:     take = 1'b0;
            wer_pkg::C_ALWAYS:    take = 1'b1;
            wer_pkg::C_NO_XFER:   take = !(s_valid && s_ready);
            wer_pkg::C_IS_FIND:   take = status.is_find;
            wer_pkg::C_IS_ADD:    take = status.is_add;
            wer_pkg::C_WALK_BUSY: take = !status.walk_done;
            wer_pkg::C_OUT_BUSY:  take = status.out_busy;
            default:              take = 1'b0;
        endcase
        step_next = take ? uw.jump : uw.next;
        ctrl.op   = uw.op;
        ctrl.xfer = s_valid && s_ready;
    end

    `WER_ASSERT_NEXT(a_leave_idle, ctrl.xfer, step_reg != wer_pkg::ST_IDLE,
                     "sequencer stayed idle after a transfer")
    `WER_ASSERT_NEXT(a_emit_done, (ctrl.op == wer_pkg::OP_EMIT) && !status.out_busy,
                     step_reg == wer_pkg::ST_IDLE,
                     "sequencer did not return to idle after emit")

endmodule

`default_nettype wire

// ===== rtl/wer_dp.sv =====
// ----------------------------------------------------------------------------
// wer_dp
// Datapath: slot memory, ring pointers, walk counters and result registers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module wer_dp (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire wer_pkg::ctrl_t                    ctrl,
    output wer_pkg::status_t                       status,
    input  wire logic [wer_pkg::ACTION_W-1:0]      s_action,
    input  wire logic [wer_pkg::HANDLE_W-1:0]      s_entry_handle,
    input  wire logic [wer_pkg::SIZE_W-1:0]        s_entry_size,
    input  wire logic [wer_pkg::OFFSET_W-1:0]      s_char_offset,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_hit,
    output logic                                   m_evicted,
    output logic [wer_pkg::HANDLE_W-1:0]           m_result_handle,
    output logic [wer_pkg::SIZE_W-1:0]             m_result_size,
    output logic [wer_pkg::INDEX_W-1:0]            m_result_index,
    output logic [wer_pkg::SIZE_W-1:0]             m_byte_in_entry
);

    typedef struct packed {
        logic [wer_pkg::HANDLE_W-1:0] handle;
        logic [wer_pkg::SIZE_W-1:0]   size;
    } slot_t;

    typedef struct packed {
        logic                         hit;
        logic                         evicted;
        logic [wer_pkg::HANDLE_W-1:0] handle;
        logic [wer_pkg::SIZE_W-1:0]   size;
        logic [wer_pkg::INDEX_W-1:0]  index;
        logic [wer_pkg::SIZE_W-1:0]   byte_pos;
    } res_t;

    slot_t slot_mem [wer_pkg::DEPTH];
    slot_t rdata_reg;
    wer_pkg::ptr_t rd_idx_reg;
    wer_pkg::ptr_t rd_addr;
    logic          mem_we;

    logic [wer_pkg::ACTION_W-1:0] act_reg;
    logic [wer_pkg::HANDLE_W-1:0] handle_reg;
    logic [wer_pkg::SIZE_W-1:0]   size_reg;
    logic [wer_pkg::OFFSET_W-1:0] offset_reg;

    wer_pkg::ptr_t wp_reg,   wp_next;
    wer_pkg::ptr_t rp_reg,   rp_next;
    logic          full_reg, full_next;
    wer_pkg::ptr_t walk_reg, walk_next;
    wer_pkg::cnt_t rem_reg,  rem_next;
    logic [wer_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic          dval_reg, dval_next;
    res_t          res_reg,  res_next;
    res_t          out_reg;
    logic          m_valid_reg;

    logic                      empty;
    wer_pkg::cnt_t             count;
    logic [wer_pkg::SUM_W-1:0] end_sum;
    logic [wer_pkg::SUM_W-1:0] offset_ext;
    logic [wer_pkg::SUM_W-1:0] diff;
    logic                      found;
    logic                      walk_done;
    logic                      load_out;

    // slot memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[wp_reg] <= '{handle: handle_reg, size: size_reg};
        end
        rdata_reg  <= slot_mem[rd_addr];
        rd_idx_reg <= rd_addr;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.xfer) begin
            act_reg    <= s_action;
            handle_reg <= s_entry_handle;
            size_reg   <= s_entry_size;
            offset_reg <= s_char_offset;
        end
        walk_reg <= walk_next;
        sum_reg  <= sum_next;
        res_reg  <= res_next;
        if (load_out) begin
            out_reg <= res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg      <= '0;
            rp_reg      <= '0;
            full_reg    <= 1'b0;
            rem_reg     <= '0;
            dval_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            wp_reg   <= wp_next;
            rp_reg   <= rp_next;
            full_reg <= full_next;
            rem_reg  <= rem_next;
            dval_reg <= dval_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        empty = !full_reg && (wp_reg == rp_reg);
        if (full_reg) begin
            count = wer_pkg::CNT_W'(wer_pkg::DEPTH);
        end else if (wp_reg >= rp_reg) begin
            count = wer_pkg::CNT_W'(wp_reg) - wer_pkg::CNT_W'(rp_reg);
        end else begin
            count = wer_pkg::CNT_W'(wp_reg) + wer_pkg::CNT_W'(wer_pkg::DEPTH)
                    - wer_pkg::CNT_W'(rp_reg);
        end

        offset_ext = wer_pkg::SUM_W'(offset_reg);
        end_sum    = sum_reg + wer_pkg::SUM_W'(rdata_reg.size);
        diff       = offset_ext - sum_reg;
        found      = dval_reg && (offset_ext < end_sum);

        wp_next   = wp_reg;
        rp_next   = rp_reg;
        full_next = full_reg;
        walk_next = walk_reg;
        rem_next  = rem_reg;
        sum_next  = sum_reg;
        dval_next = 1'b0;
        res_next  = res_reg;
        rd_addr   = rp_reg;
        mem_we    = 1'b0;
        walk_done = 1'b0;

        unique case (ctrl.op)
            wer_pkg::OP_POP_RD: begin
                rd_addr = rp_reg;
            end
            wer_pkg::OP_POP_DONE: begin
                res_next = '0;
                if ((act_reg == wer_pkg::ACT_POP) && !empty) begin
                    res_next.hit    = 1'b1;
                    res_next.handle = rdata_reg.handle;
                    res_next.size   = rdata_reg.size;
                    res_next.index  = wer_pkg::to_index(rp_reg);
                    rp_next         = wer_pkg::ring_next(rp_reg);
                    full_next       = 1'b0;
                end
            end
            wer_pkg::OP_ADD_RD: begin
                rd_addr = wp_reg;
            end
            wer_pkg::OP_ADD_WR: begin
                mem_we   = 1'b1;
                res_next = '0;
                wp_next  = wer_pkg::ring_next(wp_reg);
                if (full_reg) begin
                    // overwrite the oldest entry and drag the read pointer along
                    res_next.evicted = 1'b1;
                    res_next.handle  = rdata_reg.handle;
                    res_next.size    = rdata_reg.size;
                    res_next.index   = wer_pkg::to_index(wp_reg);
                    rp_next          = wp_next;
                end else if (wp_next == rp_reg) begin
                    full_next = 1'b1;
                end
            end
            wer_pkg::OP_FIND_INIT: begin
                walk_next = rp_reg;
                rem_next  = count;
                sum_next  = '0;
                res_next  = '0;
            end
            wer_pkg::OP_FIND_WALK: begin
                // issue the next read while comparing the entry read last cycle
                rd_addr = walk_reg;
                if (rem_reg != '0) begin
                    walk_next = wer_pkg::ring_next(walk_reg);
                    rem_next  = rem_reg - wer_pkg::CNT_W'(1);
                    dval_next = 1'b1;
                end
                if (found) begin
                    res_next.hit      = 1'b1;
                    res_next.handle   = rdata_reg.handle;
                    res_next.size     = rdata_reg.size;
                    res_next.index    = wer_pkg::to_index(rd_idx_reg);
                    res_next.byte_pos = diff[wer_pkg::SIZE_W-1:0];
                    walk_done         = 1'b1;
                end else begin
                    if (dval_reg) begin
                        sum_next = end_sum;
                    end
                    if (!dval_reg && (rem_reg == '0)) begin
                        walk_done = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign load_out         = (ctrl.op == wer_pkg::OP_EMIT) && !status.out_busy;
    assign status.is_add    = (act_reg == wer_pkg::ACT_ADD);
    assign status.is_find   = (act_reg == wer_pkg::ACT_FIND);
    assign status.walk_done = walk_done;
    assign status.out_busy  = m_valid_reg && !m_ready;

    assign m_valid         = m_valid_reg;
    assign m_hit           = out_reg.hit;
    assign m_evicted       = out_reg.evicted;
    assign m_result_handle = out_reg.handle;
    assign m_result_size   = out_reg.size;
    assign m_result_index  = out_reg.index;
    assign m_byte_in_entry = out_reg.byte_pos;

    `WER_ASSERT_IMP(a_full_ptrs, full_reg, wp_reg == rp_reg, "ring full while pointers differ")
    `WER_ASSERT_IMP(a_hit_xor_evict, m_valid_reg, !(out_reg.hit && out_reg.evicted),
                    "result both hit and evicted")
    `WER_ASSERT_IMP(a_evict_byte, m_valid_reg && out_reg.evicted, out_reg.byte_pos == '0,
                    "evicted result carries a byte position")

endmodule

`default_nettype wire

// ===== rtl/write_entry_ring_with_offset_lookup_top.sv =====
// ----------------------------------------------------------------------------
// write_entry_ring_with_offset_lookup_top
// Ring of write entries (handle, size) with add, pop and byte-offset find.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one command per transfer: s_action selects add (0),
//   find (1) or pop (2); code 3 does nothing and returns an all-zero result.
//   Every command returns exactly one result transfer on the m_ channel.
//   Add stores s_entry_handle/s_entry_size; on a full ring the oldest entry is
//   overwritten and returned with m_evicted set so its buffer can be freed.
//   Find returns the entry holding byte s_char_offset of the concatenated
//   entries with m_hit set and the position inside it, or a miss.
//   Steps: every command is accepted and dispatched; add then reads the slot
//   about to be written and writes it, pop and code 3 read the oldest slot
//   and finish, find sets up a walk from the oldest entry, reading one slot
//   per cycle until the hit or the last stored entry is compared. Each then
//   loads its result; the next command is taken in the idle step after that
//   load, so a command is not taken before the last result is loaded.
//   A stalled receiver holds the result and stalls the sequencer at its next
//   result. Reset empties the ring at once; slot contents are kept.
// ----------------------------------------------------------------------------
`default_nettype none

module write_entry_ring_with_offset_lookup_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [wer_pkg::ACTION_W-1:0]      s_action,
    input  wire logic [wer_pkg::HANDLE_W-1:0]      s_entry_handle,
    input  wire logic [wer_pkg::SIZE_W-1:0]        s_entry_size,
    input  wire logic [wer_pkg::OFFSET_W-1:0]      s_char_offset,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_hit,
    output logic                                   m_evicted,
    output logic [wer_pkg::HANDLE_W-1:0]           m_result_handle,
    output logic [wer_pkg::SIZE_W-1:0]             m_result_size,
    output logic [wer_pkg::INDEX_W-1:0]            m_result_index,
    output logic [wer_pkg::SIZE_W-1:0]             m_byte_in_entry
);

    wer_pkg::ctrl_t   ctrl;
    wer_pkg::status_t status;

    wer_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .ctrl    (ctrl)
    );

    wer_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ctrl            (ctrl),
        .status          (status),
        .s_action        (s_action),
        .s_entry_handle  (s_entry_handle),
        .s_entry_size    (s_entry_size),
        .s_char_offset   (s_char_offset),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_hit           (m_hit),
        .m_evicted       (m_evicted),
        .m_result_handle (m_result_handle),
        .m_result_size   (m_result_size),
        .m_result_index  (m_result_index),
        .m_byte_in_entry (m_byte_in_entry)
    );

endmodule

`default_nettype wire

// ===== dv/write_entry_ring_with_offset_lookup_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// write_entry_ring_with_offset_lookup_top_test
// Self-checking bench for the write-entry ring. Commands go in on the s_
// channel. A behavioural copy of the ring works out each result when the
// command transfers. Results on the m_ channel are checked in order, field by
// field. Both sides insert random idle gaps. The receiver also holds off for
// one long stretch while the sender keeps offering.
// ----------------------------------------------------------------------------

module write_entry_ring_with_offset_lookup_top_test;

    localparam logic [wer_pkg::ACTION_W-1:0] ACT_NONE = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 30;

    typedef struct packed {
        logic                         hit;
        logic                         evicted;
        logic [wer_pkg::HANDLE_W-1:0] handle;
        logic [wer_pkg::SIZE_W-1:0]   size;
        logic [wer_pkg::INDEX_W-1:0]  index;
        logic [wer_pkg::SIZE_W-1:0]   byte_pos;
    } ring_result_t;

    logic                         aclk = 1'b0;
    logic                         aresetn;
    logic                         s_valid;
    logic                         s_ready;
    logic [wer_pkg::ACTION_W-1:0] s_action;
    logic [wer_pkg::HANDLE_W-1:0] s_entry_handle;
    logic [wer_pkg::SIZE_W-1:0]   s_entry_size;
    logic [wer_pkg::OFFSET_W-1:0] s_char_offset;
    logic                         m_valid;
    logic                         m_ready;
    logic                         m_hit;
    logic                         m_evicted;
    logic [wer_pkg::HANDLE_W-1:0] m_result_handle;
    logic [wer_pkg::SIZE_W-1:0]   m_result_size;
    logic [wer_pkg::INDEX_W-1:0]  m_result_index;
    logic [wer_pkg::SIZE_W-1:0]   m_byte_in_entry;

    // shadow copy of the ring
    logic [wer_pkg::HANDLE_W-1:0] shadow_handle [wer_pkg::DEPTH];
    logic [wer_pkg::SIZE_W-1:0]   shadow_size   [wer_pkg::DEPTH];
    int                           shadow_wr;
    int                           shadow_rd;
    bit                           shadow_full;

    ring_result_t pending_results [$];
    int           error_count;
    int           sink_hold;
    bit           sink_steady;
    bit           src_steady;
    int           idle_cycles = 0;

    write_entry_ring_with_offset_lookup_top u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_entry_handle  (s_entry_handle),
        .s_entry_size    (s_entry_size),
        .s_char_offset   (s_char_offset),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_hit           (m_hit),
        .m_evicted       (m_evicted),
        .m_result_handle (m_result_handle),
        .m_result_size   (m_result_size),
        .m_result_index  (m_result_index),
        .m_byte_in_entry (m_byte_in_entry)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic int entry_count();
        if (shadow_full) begin
            return wer_pkg::DEPTH;
        end
        return (shadow_wr + wer_pkg::DEPTH - shadow_rd) % wer_pkg::DEPTH;
    endfunction

    function automatic int stored_bytes();
        int sum;
        int p;
        sum = 0;
        p = shadow_rd;
        for (int i = 0; i < entry_count(); i++) begin
            sum += shadow_size[p];
            p = (p + 1) % wer_pkg::DEPTH;
        end
        return sum;
    endfunction

    // Apply one command to the shadow ring and return the result it causes.
    function automatic ring_result_t ring_apply(
        input logic [wer_pkg::ACTION_W-1:0] act,
        input logic [wer_pkg::HANDLE_W-1:0] handle,
        input logic [wer_pkg::SIZE_W-1:0]   size,
        input logic [wer_pkg::OFFSET_W-1:0] offset);
        ring_result_t r;
        int           n;
        int           p;
        int           sum;
        bit           found;
        r = '0;
        n = entry_count();
        case (act)
            wer_pkg::ACT_ADD: begin
                if (shadow_full) begin
                    r.evicted = 1'b1;
                    r.handle  = shadow_handle[shadow_wr];
                    r.size    = shadow_size[shadow_wr];
                    r.index   = wer_pkg::INDEX_W'(shadow_wr);
                end
                shadow_handle[shadow_wr] = handle;
                shadow_size[shadow_wr]   = size;
                shadow_wr = (shadow_wr + 1) % wer_pkg::DEPTH;
                if (shadow_full) begin
                    shadow_rd = shadow_wr;
                end else if (shadow_wr == shadow_rd) begin
                    shadow_full = 1'b1;
                end
            end
            wer_pkg::ACT_FIND: begin
                p = shadow_rd;
                sum = 0;
                found = 1'b0;
                for (int i = 0; i < n; i++) begin
                    if (!found) begin
                        if (int'(offset) < sum + int'(shadow_size[p])) begin
                            found      = 1'b1;
                            r.hit      = 1'b1;
                            r.handle   = shadow_handle[p];
                            r.size     = shadow_size[p];
                            r.index    = wer_pkg::INDEX_W'(p);
                            r.byte_pos = wer_pkg::SIZE_W'(int'(offset) - sum);
                        end else begin
                            sum += shadow_size[p];
                            p = (p + 1) % wer_pkg::DEPTH;
                        end
                    end
                end
            end
            wer_pkg::ACT_POP: begin
                if (n != 0) begin
                    r.hit    = 1'b1;
                    r.handle = shadow_handle[shadow_rd];
                    r.size   = shadow_size[shadow_rd];
                    r.index  = wer_pkg::INDEX_W'(shadow_rd);
                    shadow_rd   = (shadow_rd + 1) % wer_pkg::DEPTH;
                    shadow_full = 1'b0;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [wer_pkg::SIZE_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            return '0;
        end else if (r < 15) begin
            return '1;
        end else if (r < 25) begin
            return wer_pkg::SIZE_W'($urandom_range(0, 65535));
        end
        return wer_pkg::SIZE_W'($urandom_range(1, 200));
    endfunction

    function automatic logic [wer_pkg::OFFSET_W-1:0] pick_offset();
        int r;
        int sum;
        r = $urandom_range(0, 99);
        sum = stored_bytes();
        if (r < 10) begin
            return wer_pkg::OFFSET_W'($urandom_range(0, 20'hFFFFF));
        end else if (r < 20) begin
            return wer_pkg::OFFSET_W'(sum);
        end else if (r < 30 && sum > 0) begin
            return wer_pkg::OFFSET_W'(sum - 1);
        end else if (sum == 0) begin
            return wer_pkg::OFFSET_W'($urandom_range(0, 300));
        end
        return wer_pkg::OFFSET_W'($urandom_range(0, sum - 1));
    endfunction

    // Offer one command after a gap, hold it until the transfer, then predict.
    task automatic send_cmd(input logic [wer_pkg::ACTION_W-1:0] act,
                            input logic [wer_pkg::HANDLE_W-1:0] handle,
                            input logic [wer_pkg::SIZE_W-1:0]   size,
                            input logic [wer_pkg::OFFSET_W-1:0] offset);
        int gap;
        gap = src_steady ? 0 : idle_len();
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid        <= 1'b1;
        s_action       <= act;
        s_entry_handle <= handle;
        s_entry_size   <= size;
        s_char_offset  <= offset;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        pending_results.push_back(ring_apply(act, handle, size, offset));
    endtask

    task automatic send_random(input int add_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < add_pct) begin
            send_cmd(wer_pkg::ACT_ADD, $urandom, pick_size(),
                     wer_pkg::OFFSET_W'($urandom));
        end else begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                send_cmd(wer_pkg::ACT_FIND, $urandom, wer_pkg::SIZE_W'($urandom),
                         pick_offset());
            end else if (r < 95) begin
                send_cmd(wer_pkg::ACT_POP, $urandom, wer_pkg::SIZE_W'($urandom),
                         wer_pkg::OFFSET_W'($urandom));
            end else begin
                send_cmd(ACT_NONE, $urandom, wer_pkg::SIZE_W'($urandom),
                         wer_pkg::OFFSET_W'($urandom));
            end
        end
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic test_directed();
        send_cmd(wer_pkg::ACT_POP,  32'h0, 16'h0, 20'h0);
        send_cmd(wer_pkg::ACT_FIND, 32'h0, 16'h0, 20'h0);
        send_cmd(wer_pkg::ACT_FIND, '1, '1, '1);
        send_cmd(ACT_NONE,          '1, '1, '1);
        send_cmd(wer_pkg::ACT_ADD,  32'h0, 16'h0, 20'h0);
        send_cmd(wer_pkg::ACT_ADD,  '1, '1, '1);
        send_cmd(wer_pkg::ACT_ADD,  32'hA5A5_5A5A, 16'd1, 20'h0);
        // zero-size entry is skipped, so offset 0 lands in the second entry
        send_cmd(wer_pkg::ACT_FIND, 32'h0, 16'h0, 20'd0);
        send_cmd(wer_pkg::ACT_FIND, 32'h0, 16'h0, 20'd65534);
        send_cmd(wer_pkg::ACT_FIND, 32'h0, 16'h0, 20'd65535);
        send_cmd(wer_pkg::ACT_FIND, 32'h0, 16'h0, 20'd65536);
        send_cmd(wer_pkg::ACT_FIND, 32'h0, 16'h0, '1);
        send_cmd(wer_pkg::ACT_POP,  '1, '1, '1);
        send_cmd(ACT_NONE,          32'h0, 16'h0, 20'h0);
        send_cmd(wer_pkg::ACT_FIND, 32'h0, 16'h0, 20'd0);
        send_cmd(wer_pkg::ACT_POP,  32'h0, 16'h0, 20'h0);
        send_cmd(wer_pkg::ACT_POP,  32'h0, 16'h0, 20'h0);
        send_cmd(wer_pkg::ACT_POP,  32'h0, 16'h0, 20'h0);
    endtask

    // Fill past capacity so the oldest entries are overwritten, then empty it.
    task automatic test_wrap();
        for (int i = 0; i < wer_pkg::DEPTH + 3; i++) begin
            send_cmd(wer_pkg::ACT_ADD, $urandom,
                     wer_pkg::SIZE_W'($urandom_range(0, 40)),
                     wer_pkg::OFFSET_W'($urandom));
        end
        send_cmd(wer_pkg::ACT_FIND, $urandom, wer_pkg::SIZE_W'($urandom), pick_offset());
        send_cmd(wer_pkg::ACT_FIND, $urandom, wer_pkg::SIZE_W'($urandom),
                 wer_pkg::OFFSET_W'(stored_bytes() - 1));
        for (int i = 0; i < wer_pkg::DEPTH + 1; i++) begin
            send_cmd(wer_pkg::ACT_POP, $urandom, wer_pkg::SIZE_W'($urandom),
                     wer_pkg::OFFSET_W'($urandom));
        end
    endtask

    // Stall the receiver for a long stretch while commands keep coming.
    task automatic test_backpressure();
        src_steady = 1'b1;
        sink_hold = 150;
        for (int i = 0; i < 12; i++) begin
            send_random(50);
        end
        src_steady = 1'b0;
        drain();
    endtask

    task automatic test_random();
        int add_pct;
        for (int chunk = 0; chunk < 16; chunk++) begin
            case ($urandom_range(0, 4))
                0:       add_pct = 15;
                1:       add_pct = 35;
                2:       add_pct = 50;
                3:       add_pct = 65;
                default: add_pct = 85;
            endcase
            src_steady  = ($urandom_range(0, 5) == 0);
            sink_steady = ($urandom_range(0, 5) == 0);
            for (int i = 0; i < 50; i++) begin
                send_random(add_pct);
            end
        end
        src_steady  = 1'b0;
        sink_steady = 1'b0;
    endtask

    // Receiver: random stalls, plus a long hold-off when one is requested.
    initial begin : sink
        int stall_left;
        int run_left;
        stall_left = 0;
        run_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_hold > 0) begin
                m_ready <= 1'b0;
                sink_hold--;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (run_left > 0) begin
                    run_left--;
                end else begin
                    stall_left = sink_steady ? 0 : idle_len();
                    run_left = $urandom_range(0, 20);
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        ring_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result transfer, expected none, actual hit=%0b ev=%0b",
                         $time, m_hit, m_evicted);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("hit", want.hit, m_hit);
                check_field("evicted", want.evicted, m_evicted);
                check_field("result_handle", want.handle, m_result_handle);
                check_field("result_size", want.size, m_result_size);
                check_field("result_index", want.index, m_result_index);
                check_field("byte_in_entry", want.byte_pos, m_byte_in_entry);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL write_entry_ring_with_offset_lookup_top");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_action       = wer_pkg::ACT_ADD;
        s_entry_handle = '0;
        s_entry_size   = '0;
        s_char_offset  = '0;
        error_count    = 0;
        sink_hold      = 0;
        sink_steady    = 1'b0;
        src_steady     = 1'b0;
        shadow_wr      = 0;
        shadow_rd      = 0;
        shadow_full    = 1'b0;
        for (int i = 0; i < wer_pkg::DEPTH; i++) begin
            shadow_handle[i] = '0;
            shadow_size[i]   = '0;
        end
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_wrap();
        drain();
        test_backpressure();
        test_random();
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("PASS write_entry_ring_with_offset_lookup_top");
        end else begin
            $display("FAIL write_entry_ring_with_offset_lookup_top");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/wer_pkg.sv
rtl/wer_seq.sv
rtl/wer_dp.sv
rtl/write_entry_ring_with_offset_lookup_top.sv
dv/write_entry_ring_with_offset_lookup_top_test.sv
